@@ hw/rtl/qvr_pkg.sv @@
// Shared constants for the quaternion vector rotation pipeline.
package qvr_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int QUAT_BITS          = 16;
    localparam int PROD_SHIFT         = 28;
    localparam int SQ_W               = 30;
    localparam int K_W                = 31;
    localparam int NUM_STAGES         = 6;

    localparam logic signed [QUAT_BITS-1:0] QUAT_ONE     = 16'sd16384;
    localparam logic signed [QUAT_BITS-1:0] QUAT_NEG_ONE = -16'sd16384;

    typedef logic signed [QUAT_BITS-1:0] quat_t;
    typedef logic [NUM_STAGES-1:0]       stage_ld_t;

endpackage

@@ hw/rtl/qvr_ctrl.sv @@
// Valid and ready control of the pipeline stages.
module qvr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output qvr_pkg::stage_ld_t ld
);

    localparam int NS = qvr_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   ready;

    // A stage takes a new request when it is empty or its contents move on.
    always_comb begin
        ready[NS] = m_tready;
        for (int n = NS - 1; n >= 0; n--) begin
            ready[n] = !valid_reg[n] || ready[n+1];
        end
        for (int n = 0; n < NS; n++) begin
            ld[n] = ready[n];
            if (n == 0) begin
                valid_next[n] = s_tvalid;
            end else begin
                valid_next[n] = valid_reg[n-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int n = 0; n < NS; n++) begin
                if (ld[n]) begin
                    valid_reg[n] <= valid_next[n];
                end
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NS-1];

endmodule

@@ hw/rtl/qvr_front.sv @@
// Front stages: quaternion clamping, pairwise products, dot, cross and scale sums.
module qvr_front #(
    parameter int COMPONENT_BITS = qvr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             aclk,
    input  qvr_pkg::stage_ld_t               ld,
    input  logic signed [COMPONENT_BITS-1:0] vec_in [3],
    input  qvr_pkg::quat_t                   quat_w,
    input  qvr_pkg::quat_t                   quat_u [3],
    output logic signed [COMPONENT_BITS+qvr_pkg::QUAT_BITS-1:0] duv,
    output logic signed [COMPONENT_BITS+qvr_pkg::QUAT_BITS-1:0] cr [3],
    output logic signed [qvr_pkg::K_W-1:0]   kf,
    output qvr_pkg::quat_t                   s_out,
    output qvr_pkg::quat_t                   u_out [3],
    output logic signed [COMPONENT_BITS-1:0] v_out [3]
);

    localparam int CB   = COMPONENT_BITS;
    localparam int PW   = CB + qvr_pkg::QUAT_BITS;
    localparam int SQ_W = qvr_pkg::SQ_W;
    localparam int K_W  = qvr_pkg::K_W;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic signed [CB-1:0]   v1_reg [3], v1_next [3];
    qvr_pkg::quat_t         s1_reg, s1_next;
    qvr_pkg::quat_t         u1_reg [3], u1_next [3];

    logic signed [PW-1:0]   pd_reg [3], pd_next [3];
    logic signed [PW-1:0]   pp_reg [3], pp_next [3];
    logic signed [PW-1:0]   pn_reg [3], pn_next [3];
    logic signed [SQ_W-1:0] sq_reg [3], sq_next [3];
    logic signed [SQ_W-1:0] ss_reg, ss_next;
    logic signed [CB-1:0]   v2_reg [3];
    qvr_pkg::quat_t         s2_reg;
    qvr_pkg::quat_t         u2_reg [3];

    logic signed [PW-1:0]   duv_reg, duv_next;
    logic signed [PW-1:0]   cr_reg [3], cr_next [3];
    logic signed [K_W-1:0]  k_reg, k_next;
    logic signed [CB-1:0]   v3_reg [3];
    qvr_pkg::quat_t         s3_reg;
    qvr_pkg::quat_t         u3_reg [3];

    function automatic qvr_pkg::quat_t clamp_q(input qvr_pkg::quat_t q);
        qvr_pkg::quat_t r;
        r = q;
        if (q < qvr_pkg::QUAT_NEG_ONE) begin
            r = qvr_pkg::QUAT_NEG_ONE;
        end else if (q > qvr_pkg::QUAT_ONE) begin
            r = qvr_pkg::QUAT_ONE;
        end
        return r;
    endfunction

    always_comb begin
        s1_next = clamp_q(quat_w);
        for (int c = 0; c < 3; c++) begin
            v1_next[c] = vec_in[c];
            u1_next[c] = clamp_q(quat_u[c]);
        end
    end

    always_comb begin
        ss_next = SQ_W'(s1_reg) * SQ_W'(s1_reg);
        for (int c = 0; c < 3; c++) begin
            pd_next[c] = PW'(u1_reg[c]) * PW'(v1_reg[c]);
            pp_next[c] = PW'(u1_reg[NXT[c]]) * PW'(v1_reg[PRV[c]]);
            pn_next[c] = PW'(u1_reg[PRV[c]]) * PW'(v1_reg[NXT[c]]);
            sq_next[c] = SQ_W'(u1_reg[c]) * SQ_W'(u1_reg[c]);
        end
    end

    always_comb begin
        duv_next = pd_reg[0] + pd_reg[1] + pd_reg[2];
        k_next   = K_W'(ss_reg) - K_W'(sq_reg[0]) - K_W'(sq_reg[1]) - K_W'(sq_reg[2]);
        for (int c = 0; c < 3; c++) begin
            cr_next[c] = pp_reg[c] - pn_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            v1_reg <= v1_next;
            s1_reg <= s1_next;
            u1_reg <= u1_next;
        end
        if (ld[1]) begin
            pd_reg <= pd_next;
            pp_reg <= pp_next;
            pn_reg <= pn_next;
            sq_reg <= sq_next;
            ss_reg <= ss_next;
            v2_reg <= v1_reg;
            s2_reg <= s1_reg;
            u2_reg <= u1_reg;
        end
        if (ld[2]) begin
            duv_reg <= duv_next;
            cr_reg  <= cr_next;
            k_reg   <= k_next;
            v3_reg  <= v2_reg;
            s3_reg  <= s2_reg;
            u3_reg  <= u2_reg;
        end
    end

    assign duv   = duv_reg;
    assign cr    = cr_reg;
    assign kf    = k_reg;
    assign s_out = s3_reg;
    assign u_out = u3_reg;
    assign v_out = v3_reg;

endmodule

@@ hw/rtl/qvr_back.sv @@
// Back stages: weighted products, rounded sum and saturation of each component.
module qvr_back #(
    parameter int COMPONENT_BITS = qvr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             aclk,
    input  qvr_pkg::stage_ld_t               ld,
    input  logic signed [COMPONENT_BITS+qvr_pkg::QUAT_BITS-1:0] duv,
    input  logic signed [COMPONENT_BITS+qvr_pkg::QUAT_BITS-1:0] cr [3],
    input  logic signed [qvr_pkg::K_W-1:0]   kf,
    input  qvr_pkg::quat_t                   s_in,
    input  qvr_pkg::quat_t                   u_in [3],
    input  logic signed [COMPONENT_BITS-1:0] v_in [3],
    output logic        [COMPONENT_BITS-1:0] rot [3],
    output logic                             saturated
);

    localparam int CB    = COMPONENT_BITS;
    localparam int ACC_W = CB + 2 * qvr_pkg::QUAT_BITS;
    localparam int SH    = qvr_pkg::PROD_SHIFT;
    localparam int SC_W  = ACC_W - SH;
    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

    logic signed [ACC_W-1:0] pa_reg [3], pa_next [3];
    logic signed [ACC_W-1:0] pb_reg [3], pb_next [3];
    logic signed [ACC_W-1:0] pc_reg [3], pc_next [3];
    logic signed [SC_W-1:0]  sc_reg [3], sc_next [3];
    logic [CB-1:0]           rot_reg [3], rot_next [3];
    logic                    sat_reg, sat_next;
    logic signed [ACC_W-1:0] acc [3];
    logic [SC_W-CB:0]        top_bits;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            pa_next[c] = ACC_W'(duv) * ACC_W'(u_in[c]);
            pb_next[c] = ACC_W'(kf) * ACC_W'(v_in[c]);
            pc_next[c] = ACC_W'(s_in) * ACC_W'(cr[c]);
        end
    end

    // Round to nearest with ties upward, then drop the fraction bits.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c]     = (pa_reg[c] <<< 1) + pb_reg[c] + (pc_reg[c] <<< 1) + RND;
            sc_next[c] = SC_W'(acc[c] >>> SH);
        end
    end

    always_comb begin
        sat_next = 1'b0;
        top_bits = '0;
        for (int c = 0; c < 3; c++) begin
            top_bits = sc_reg[c][SC_W-1:CB-1];
            if ((top_bits == '0) || (top_bits == '1)) begin
                rot_next[c] = sc_reg[c][CB-1:0];
            end else begin
                sat_next = 1'b1;
                if (sc_reg[c][SC_W-1]) begin
                    rot_next[c] = {1'b1, {(CB-1){1'b0}}};
                end else begin
                    rot_next[c] = {1'b0, {(CB-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (ld[4]) begin
            sc_reg <= sc_next;
        end
        if (ld[5]) begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign rot       = rot_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/quaternion_vector_rotate.sv @@
// Top level of the quaternion vector rotation pipeline.
// This block rotates a signed fixed-point 3-vector by a Q1.14 quaternion that is taken
// to be of unit length, computing 2(u.v)u + (s*s - u.u)v + 2s(u x v), rounding to
// nearest with ties upward, and saturating each component; quaternion parts outside
// plus or minus one are clamped first. It takes one request per cycle unless a stall
// holds the first stage, and returns its result through six register stages (input
// clamping, products, sums, weighted products, rounding, saturation); a stall on the
// output holds each occupied stage with no empty stage after it; the other stages load.
module quaternion_vector_rotate #(
    parameter int COMPONENT_BITS = qvr_pkg::COMPONENT_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // vec_x, vec_y, vec_z, quat_w, quat_i, quat_j, quat_k, zero fill
    input  logic [((3*COMPONENT_BITS+4*qvr_pkg::QUAT_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // rot_x, rot_y, rot_z, zero fill
    output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
    // saturated
    output logic m_tuser
);

    localparam int CB       = COMPONENT_BITS;
    localparam int QB       = qvr_pkg::QUAT_BITS;
    localparam int PW       = CB + QB;
    localparam int M_DATA_W = ((3*CB+7)/8)*8;
    localparam int QOFS     = 3 * CB;

    qvr_pkg::stage_ld_t          ld;
    logic signed [CB-1:0]        vec_in [3];
    qvr_pkg::quat_t              quat_w;
    qvr_pkg::quat_t              quat_u [3];
    logic signed [PW-1:0]        duv;
    logic signed [PW-1:0]        cr [3];
    logic signed [qvr_pkg::K_W-1:0] kf;
    qvr_pkg::quat_t              s_mid;
    qvr_pkg::quat_t              u_mid [3];
    logic signed [CB-1:0]        v_mid [3];
    logic [CB-1:0]               rot [3];
    logic                        saturated;

    assign vec_in[0] = s_tdata[CB-1:0];
    assign vec_in[1] = s_tdata[2*CB-1:CB];
    assign vec_in[2] = s_tdata[3*CB-1:2*CB];
    assign quat_w    = s_tdata[QOFS+QB-1:QOFS];
    assign quat_u[0] = s_tdata[QOFS+2*QB-1:QOFS+QB];
    assign quat_u[1] = s_tdata[QOFS+3*QB-1:QOFS+2*QB];
    assign quat_u[2] = s_tdata[QOFS+4*QB-1:QOFS+3*QB];

    qvr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ld       (ld)
    );

    qvr_front #(
        .COMPONENT_BITS (CB)
    ) u_front (
        .aclk   (aclk),
        .ld     (ld),
        .vec_in (vec_in),
        .quat_w (quat_w),
        .quat_u (quat_u),
        .duv    (duv),
        .cr     (cr),
        .kf     (kf),
        .s_out  (s_mid),
        .u_out  (u_mid),
        .v_out  (v_mid)
    );

    qvr_back #(
        .COMPONENT_BITS (CB)
    ) u_back (
        .aclk      (aclk),
        .ld        (ld),
        .duv       (duv),
        .cr        (cr),
        .kf        (kf),
        .s_in      (s_mid),
        .u_in      (u_mid),
        .v_in      (v_mid),
        .rot       (rot),
        .saturated (saturated)
    );

    assign m_tdata = M_DATA_W'({rot[2], rot[1], rot[0]});
    assign m_tuser = saturated;

endmodule
